/* sv/shell_command_lexer_assert.svh */
// Assertion macros for the shell command lexer.
// The enclosing module supplies clk and rst.
`ifndef SHELL_COMMAND_LEXER_ASSERT_SVH
`define SHELL_COMMAND_LEXER_ASSERT_SVH

`ifndef SYNTHESIS

`define SCL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SCL_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SCL_ASSERT(name, prop, msg)

`define SCL_ASSERT_RST(name, prop, msg)

`endif

`endif

/* sv/scl_pkg.sv */
package scl_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_SQ_EMPTY = 3'd1;
  localparam logic [2:0] M_SQ_TEXT  = 3'd2;
  localparam logic [2:0] M_DQ_EMPTY = 3'd3;
  localparam logic [2:0] M_DQ_TEXT  = 3'd4;
  localparam logic [2:0] M_DOLLAR   = 3'd5;
  localparam logic [2:0] M_WORD     = 3'd6;

  localparam logic [1:0] ANG_NONE = 2'd0;
  localparam logic [1:0] ANG_GT   = 2'd1;
  localparam logic [1:0] ANG_LT   = 2'd2;

  localparam logic [3:0] T_SPACE   = 4'd0;
  localparam logic [3:0] T_SINGLE  = 4'd1;
  localparam logic [3:0] T_DOUBLE  = 4'd2;
  localparam logic [3:0] T_PIPE    = 4'd3;
  localparam logic [3:0] T_APPEND  = 4'd4;
  localparam logic [3:0] T_HEREDOC = 4'd5;
  localparam logic [3:0] T_OUT     = 4'd6;
  localparam logic [3:0] T_IN      = 4'd7;
  localparam logic [3:0] T_DOLLAR  = 4'd8;
  localparam logic [3:0] T_WORD    = 4'd9;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IW  = $clog2(MAX_RES);
  localparam int unsigned RES_CW  = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] token_type;
    logic       token_start;
    logic       has_char;
    logic       line_end;
    logic       run_last;
  } res_t;

  function automatic res_t mk_res(logic [7:0] ch, logic [3:0] token_type,
                                  logic token_start, logic has_char, logic line_end);
    res_t r;
    r.ch          = ch;
    r.token_type  = token_type;
    r.token_start = token_start;
    r.has_char    = has_char;
    r.line_end    = line_end;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic logic is_stop(logic [7:0] c);
    return c == CH_SPACE || c == CH_PIPE || c == CH_GT || c == CH_LT ||
           c == CH_DOLLAR || c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

endpackage

/* sv/scl_byte_if.sv */
interface scl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;

  modport source (output valid, output byte_req, input ready);
  modport sink (input valid, input byte_req, output ready);
endinterface

/* sv/scl_tok_if.sv */
interface scl_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic [3:0] token_type;
  logic       token_start;
  logic       has_char;
  logic       line_end;
  logic       run_last;

  modport source (output valid, output ch, output token_type, output token_start,
                  output has_char, output line_end, output run_last, input ready);
  modport sink (input valid, input ch, input token_type, input token_start,
                input has_char, input line_end, input run_last, output ready);
endinterface

/* sv/shell_command_lexer.sv */
// Shell command line tokenizer. Bytes of a command line enter on line_bytes, one
// request per cycle when ready; a zero byte ends the line and returns the lexer to
// its start state. Each byte yields zero to two token items on tokens, one item
// per cycle while tokens.ready is high, the last flagged by run_last. The lexer
// decision for a byte is made in the cycle it is accepted and its items are loaded
// into a four-entry result bank that drains in order; the next byte is accepted as
// soon as the bank is empty or its final item is taken. A byte with at most one
// item sustains one byte per clock while tokens.ready is high; more items stall
// the next byte. A pending '>' or '<' is held until the next byte shows whether it
// doubles; a space run is held until the next token starts, delaying its items.
`include "shell_command_lexer_assert.svh"

module shell_command_lexer (
  input  logic              clk,
  input  logic              rst,
  scl_byte_if.sink          line_bytes,
  scl_tok_if.source         tokens
);

  logic [2:0] mode, mode_next;
  logic [1:0] angle, angle_next;
  logic       pend_space, pend_space_next;
  logic       any_tok, any_tok_next;

  scl_pkg::res_t               bank [scl_pkg::MAX_RES];
  logic [scl_pkg::RES_CW-1:0]  cnt;

  scl_pkg::res_t               res  [scl_pkg::MAX_RES];
  logic [scl_pkg::RES_CW-1:0]  nres;

  logic acc, take;

  assign take = tokens.valid && tokens.ready;
  assign line_bytes.ready = (cnt == '0) ||
                            (cnt == scl_pkg::RES_CW'(1) && tokens.ready);
  assign acc = line_bytes.valid && line_bytes.ready;

  assign tokens.valid       = cnt != '0;
  assign tokens.ch          = bank[0].ch;
  assign tokens.token_type  = bank[0].token_type;
  assign tokens.token_start = bank[0].token_start;
  assign tokens.has_char    = bank[0].has_char;
  assign tokens.line_end    = bank[0].line_end;
  assign tokens.run_last    = bank[0].run_last;

  always_comb begin
    logic [7:0] c;
    logic       run_idle;
    logic       empty_q;
    c        = line_bytes.byte_req;
    run_idle = 1'b0;
    empty_q  = 1'b0;
    nres     = '0;
    for (int i = 0; i < scl_pkg::MAX_RES; i++) begin
      res[i] = scl_pkg::mk_res(scl_pkg::CH_NUL, scl_pkg::T_SPACE, 1'b0, 1'b0, 1'b0);
    end
    mode_next       = (mode > scl_pkg::M_WORD) ? scl_pkg::M_IDLE : mode;
    angle_next      = (angle > scl_pkg::ANG_LT) ? scl_pkg::ANG_NONE : angle;
    pend_space_next = pend_space;
    any_tok_next    = any_tok;

    if (c == scl_pkg::CH_NUL) begin
      if (angle_next == scl_pkg::ANG_GT) begin
        res[nres[scl_pkg::RES_IW-1:0]] =
          scl_pkg::mk_res(scl_pkg::CH_GT, scl_pkg::T_OUT, 1'b1, 1'b1, 1'b0);
        nres = nres + 1'b1;
      end else if (angle_next == scl_pkg::ANG_LT) begin
        res[nres[scl_pkg::RES_IW-1:0]] =
          scl_pkg::mk_res(scl_pkg::CH_LT, scl_pkg::T_IN, 1'b1, 1'b1, 1'b0);
        nres = nres + 1'b1;
      end
      if (mode_next == scl_pkg::M_SQ_EMPTY) begin
        res[nres[scl_pkg::RES_IW-1:0]] =
          scl_pkg::mk_res(scl_pkg::CH_NUL, scl_pkg::T_SINGLE, 1'b1, 1'b0, 1'b0);
        nres = nres + 1'b1;
      end else if (mode_next == scl_pkg::M_DQ_EMPTY) begin
        res[nres[scl_pkg::RES_IW-1:0]] =
          scl_pkg::mk_res(scl_pkg::CH_NUL, scl_pkg::T_DOUBLE, 1'b1, 1'b0, 1'b0);
        nres = nres + 1'b1;
      end
      res[nres[scl_pkg::RES_IW-1:0]] =
        scl_pkg::mk_res(scl_pkg::CH_NUL, scl_pkg::T_SPACE, 1'b0, 1'b0, 1'b1);
      nres = nres + 1'b1;
      mode_next       = scl_pkg::M_IDLE;
      angle_next      = scl_pkg::ANG_NONE;
      pend_space_next = 1'b0;
      any_tok_next    = 1'b0;
    end else if (angle_next != scl_pkg::ANG_NONE) begin
      if (angle_next == scl_pkg::ANG_GT && c == scl_pkg::CH_GT) begin
        res[0] = scl_pkg::mk_res(scl_pkg::CH_GT, scl_pkg::T_APPEND, 1'b1, 1'b1, 1'b0);
        res[1] = scl_pkg::mk_res(scl_pkg::CH_GT, scl_pkg::T_APPEND, 1'b0, 1'b1, 1'b0);
        nres = scl_pkg::RES_CW'(2);
      end else if (angle_next == scl_pkg::ANG_LT && c == scl_pkg::CH_LT) begin
        res[0] = scl_pkg::mk_res(scl_pkg::CH_LT, scl_pkg::T_HEREDOC, 1'b1, 1'b1, 1'b0);
        res[1] = scl_pkg::mk_res(scl_pkg::CH_LT, scl_pkg::T_HEREDOC, 1'b0, 1'b1, 1'b0);
        nres = scl_pkg::RES_CW'(2);
      end else begin
        if (angle_next == scl_pkg::ANG_GT) begin
          res[0] = scl_pkg::mk_res(scl_pkg::CH_GT, scl_pkg::T_OUT, 1'b1, 1'b1, 1'b0);
        end else begin
          res[0] = scl_pkg::mk_res(scl_pkg::CH_LT, scl_pkg::T_IN, 1'b1, 1'b1, 1'b0);
        end
        nres = scl_pkg::RES_CW'(1);
        run_idle = 1'b1;
      end
      angle_next = scl_pkg::ANG_NONE;
    end else begin
      unique case (mode_next)
        scl_pkg::M_SQ_EMPTY, scl_pkg::M_SQ_TEXT: begin
          empty_q = mode_next == scl_pkg::M_SQ_EMPTY;
          if (c == scl_pkg::CH_SQUOTE) begin
            if (empty_q) begin
              res[0] = scl_pkg::mk_res(scl_pkg::CH_NUL, scl_pkg::T_SINGLE, 1'b1, 1'b0, 1'b0);
              nres = scl_pkg::RES_CW'(1);
            end
            mode_next = scl_pkg::M_IDLE;
          end else begin
            res[0] = scl_pkg::mk_res(c, scl_pkg::T_SINGLE, empty_q, 1'b1, 1'b0);
            nres = scl_pkg::RES_CW'(1);
            mode_next = scl_pkg::M_SQ_TEXT;
          end
        end
        scl_pkg::M_DQ_EMPTY, scl_pkg::M_DQ_TEXT: begin
          empty_q = mode_next == scl_pkg::M_DQ_EMPTY;
          if (c == scl_pkg::CH_DQUOTE) begin
            if (empty_q) begin
              res[0] = scl_pkg::mk_res(scl_pkg::CH_NUL, scl_pkg::T_DOUBLE, 1'b1, 1'b0, 1'b0);
              nres = scl_pkg::RES_CW'(1);
            end
            mode_next = scl_pkg::M_IDLE;
          end else begin
            res[0] = scl_pkg::mk_res(c, scl_pkg::T_DOUBLE, empty_q, 1'b1, 1'b0);
            nres = scl_pkg::RES_CW'(1);
            mode_next = scl_pkg::M_DQ_TEXT;
          end
        end
        scl_pkg::M_DOLLAR, scl_pkg::M_WORD: begin
          if (scl_pkg::is_stop(c)) begin
            mode_next = scl_pkg::M_IDLE;
            run_idle  = 1'b1;
          end else begin
            res[0] = scl_pkg::mk_res(c, (mode_next == scl_pkg::M_DOLLAR) ?
                                     scl_pkg::T_DOLLAR : scl_pkg::T_WORD,
                                     1'b0, 1'b1, 1'b0);
            nres = scl_pkg::RES_CW'(1);
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase
    end

    if (run_idle) begin
      if (c == scl_pkg::CH_SPACE) begin
        if (any_tok) begin
          pend_space_next = 1'b1;
        end
      end else begin
        if (pend_space) begin
          res[nres[scl_pkg::RES_IW-1:0]] =
            scl_pkg::mk_res(scl_pkg::CH_SPACE, scl_pkg::T_SPACE, 1'b1, 1'b1, 1'b0);
          nres = nres + 1'b1;
          pend_space_next = 1'b0;
        end
        any_tok_next = 1'b1;
        priority if (c == scl_pkg::CH_SQUOTE) begin
          mode_next = scl_pkg::M_SQ_EMPTY;
        end else if (c == scl_pkg::CH_DQUOTE) begin
          mode_next = scl_pkg::M_DQ_EMPTY;
        end else if (c == scl_pkg::CH_PIPE) begin
          res[nres[scl_pkg::RES_IW-1:0]] =
            scl_pkg::mk_res(c, scl_pkg::T_PIPE, 1'b1, 1'b1, 1'b0);
          nres = nres + 1'b1;
        end else if (c == scl_pkg::CH_GT) begin
          angle_next = scl_pkg::ANG_GT;
        end else if (c == scl_pkg::CH_LT) begin
          angle_next = scl_pkg::ANG_LT;
        end else if (c == scl_pkg::CH_DOLLAR) begin
          res[nres[scl_pkg::RES_IW-1:0]] =
            scl_pkg::mk_res(c, scl_pkg::T_DOLLAR, 1'b1, 1'b1, 1'b0);
          nres = nres + 1'b1;
          mode_next = scl_pkg::M_DOLLAR;
        end else begin
          res[nres[scl_pkg::RES_IW-1:0]] =
            scl_pkg::mk_res(c, scl_pkg::T_WORD, 1'b1, 1'b1, 1'b0);
          nres = nres + 1'b1;
          mode_next = scl_pkg::M_WORD;
        end
      end
    end

    if (nres != '0) begin
      res[nres[scl_pkg::RES_IW-1:0] - 1'b1].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      mode       <= scl_pkg::M_IDLE;
      angle      <= scl_pkg::ANG_NONE;
      pend_space <= 1'b0;
      any_tok    <= 1'b0;
    end else if (acc) begin
      cnt        <= nres;
      mode       <= mode_next;
      angle      <= angle_next;
      pend_space <= pend_space_next;
      any_tok    <= any_tok_next;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  // load on accept, else advance the bank toward the output slot
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < scl_pkg::MAX_RES; i++) begin
        bank[i] <= res[i];
      end
    end else if (take) begin
      for (int i = 0; i < scl_pkg::MAX_RES - 1; i++) begin
        bank[i] <= bank[i + 1];
      end
    end
  end

  `SCL_ASSERT(a_end_is_last, tokens.valid && tokens.line_end |-> tokens.run_last,
              "line end not last")
  `SCL_ASSERT(a_no_char_zero,
              tokens.valid && !tokens.has_char |-> tokens.ch == scl_pkg::CH_NUL,
              "empty item carries a character")
  `SCL_ASSERT(a_line_clears,
              acc && line_bytes.byte_req == scl_pkg::CH_NUL |=>
                mode == scl_pkg::M_IDLE && angle == scl_pkg::ANG_NONE &&
                !pend_space && !any_tok,
              "state not cleared at line end")
  `SCL_ASSERT(a_ready_empty, cnt == '0 |-> line_bytes.ready, "not ready with empty bank")
  `SCL_ASSERT_RST(a_reset,
                  rst |=> cnt == '0 && mode == scl_pkg::M_IDLE &&
                    angle == scl_pkg::ANG_NONE,
                  "reset state wrong")

endmodule
